>>> src/sils_pkg.sv
`timescale 1ns / 1ps
package sils_pkg;
	localparam int MaxUnknowns  = 16;
	localparam int ValueBits    = 32;
	localparam int FractionBits = 16;
	localparam int OmegaBits    = 16;

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_START  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		METH_JACOBI = 2'd0,
		METH_GS     = 2'd1,
		METH_SOR    = 2'd2,
		METH_OTHER  = 2'd3
	} method_t;

	typedef enum logic [1:0] {
		OUT_CONVERGED = 2'd0,
		OUT_LIMIT     = 2'd1,
		OUT_ZERO_DIAG = 2'd2
	} outcome_t;

	localparam int CfgMethod = 0;
	localparam int CfgOmega  = 1;
	localparam int CfgTol    = 2;
	localparam int CfgMaxIt  = 3;
	localparam int CfgSize   = 4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIAG,
		ST_ROW_INIT,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_DIV,
		ST_SOR_MUL,
		ST_UPDATE,
		ST_JAC_COPY,
		ST_SWEEP_END,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init;       // clear solution and largest change
		logic diag_rd;    // read diagonal at row_idx
		logic row_init;   // read A[i][0]; rhs enters the accumulator at the first mac_mul
		logic mac_mul;    // multiply A*x
		logic mac_acc;    // subtract product
		logic div_start;  // launch divider
		logic sor_mul;    // omega multiply
		logic update;     // write x; in-place methods also track change
		logic jac_copy;   // Jacobi copy-back with change
		logic sweep_clr;  // clear largest change
		logic emit;       // drive a result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic diag_zero;
		logic div_done;
		logic converged;
	} stat_t;
endpackage

>>> src/sils_divider.sv
`timescale 1ns / 1ps
module sils_divider
	import sils_pkg::*;
#(
	parameter int VALUE_BITS    = ValueBits,
	parameter int FRACTION_BITS = FractionBits
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [VALUE_BITS-1:0] numer,
	input  logic signed [VALUE_BITS-1:0] denom,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] quot
);
	localparam int NB = VALUE_BITS + FRACTION_BITS;
	localparam int CB = $clog2(NB + 1);

	logic [NB-1:0]         dvd_q;
	logic [NB-1:0]         quo_q;
	logic [VALUE_BITS:0]   rem_q;
	logic [VALUE_BITS-1:0] dsr_q;
	logic                  neg_q;
	logic [CB-1:0]         cnt_q;
	logic                  run_q;
	logic [VALUE_BITS-1:0] un, ud;
	logic [VALUE_BITS:0]   shifted;
	logic                  ge;
	logic [VALUE_BITS:0]   lim;

	assign un = numer[VALUE_BITS-1] ? (~numer + 1'b1) : numer;
	assign ud = denom[VALUE_BITS-1] ? (~denom + 1'b1) : denom;
	assign shifted = {rem_q[VALUE_BITS-1:0], dvd_q[NB-1]};
	assign ge = shifted >= {1'b0, dsr_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CB'(NB);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {un, {FRACTION_BITS{1'b0}}};
			dsr_q <= ud;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= numer[VALUE_BITS-1] ^ denom[VALUE_BITS-1];
		end else if (run_q) begin
			dvd_q <= {dvd_q[NB-2:0], 1'b0};
			rem_q <= ge ? (shifted - {1'b0, dsr_q}) : shifted;
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

	// saturate the magnitude to the signed range
	always_comb begin
		lim = {2'b0, {(VALUE_BITS-1){1'b1}}} + (VALUE_BITS+1)'(neg_q);
		if (quo_q > NB'(lim)) begin
			quot = neg_q ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
		end else if (neg_q) begin
			quot = VALUE_BITS'(~quo_q + 1'b1);
		end else begin
			quot = VALUE_BITS'(quo_q);
		end
	end
endmodule

>>> src/sils_datapath.sv
`timescale 1ns / 1ps
module sils_datapath
	import sils_pkg::*;
#(
	parameter int MAX_UNKNOWNS  = MaxUnknowns,
	parameter int VALUE_BITS    = ValueBits,
	parameter int FRACTION_BITS = FractionBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_a,
	input  logic                          wr_b,
	input  logic [$clog2(MAX_UNKNOWNS)-1:0] wr_row,
	input  logic [$clog2(MAX_UNKNOWNS)-1:0] wr_col,
	input  logic signed [VALUE_BITS-1:0]  wr_val,
	input  cmd_t                          cmd,
	input  logic [$clog2(MAX_UNKNOWNS)-1:0] row_idx,
	input  logic [$clog2(MAX_UNKNOWNS)-1:0] col_idx,
	input  logic                          col_skip,
	input  method_t                       meth,
	input  logic [16:0]                   omega,
	input  logic [30:0]                   tol,
	output stat_t                         stat,
	output logic signed [31:0]            out_value
);
	localparam int IB  = $clog2(MAX_UNKNOWNS);
	localparam int VB  = VALUE_BITS;
	localparam int PW  = 2 * VB;
	localparam logic signed [VB-1:0] QMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] QMIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [VB-1:0] ONE  =
		(FRACTION_BITS < VB - 1) ? VB'(1) << FRACTION_BITS : QMAX;

	logic signed [VB-1:0] mat_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
	logic signed [VB-1:0] rhs_mem [MAX_UNKNOWNS];
	logic signed [VB-1:0] x_now_q  [MAX_UNKNOWNS];
	logic signed [VB-1:0] x_prev_q [MAX_UNKNOWNS];
	logic signed [VB-1:0] a_rd_q, b_rd_q;
	logic signed [VB-1:0] acc_q, xi_q, g_q;
	logic signed [VB-1:0] xnew;
	logic signed [PW-1:0] prod_q;
	logic signed [VB-1:0] big_q;
	logic signed [VB-1:0] div_q;
	logic                 div_done;
	logic [IB-1:0]        rd_col;

	function automatic logic signed [VB-1:0] sat(input logic signed [PW:0] v);
		if (v > PW'(QMAX)) return QMAX;
		if (v < $signed({{(PW-VB+1){1'b1}}, QMIN})) return QMIN;
		return v[VB-1:0];
	endfunction

	function automatic logic signed [VB-1:0] sub_s(input logic signed [VB-1:0] a,
		input logic signed [VB-1:0] b);
		logic signed [VB:0] d;
		d = {a[VB-1], a} - {b[VB-1], b};
		if (d[VB] != d[VB-1]) return d[VB] ? QMIN : QMAX;
		return d[VB-1:0];
	endfunction

	function automatic logic signed [VB-1:0] add_s(input logic signed [VB-1:0] a,
		input logic signed [VB-1:0] b);
		logic signed [VB:0] d;
		d = {a[VB-1], a} + {b[VB-1], b};
		if (d[VB] != d[VB-1]) return d[VB] ? QMIN : QMAX;
		return d[VB-1:0];
	endfunction

	function automatic logic signed [VB-1:0] abs_s(input logic signed [VB-1:0] a);
		if (a == QMIN) return QMAX;
		return a[VB-1] ? -a : a;
	endfunction

	// shift a full product toward zero, then saturate
	function automatic logic signed [VB-1:0] shr_s(input logic signed [PW-1:0] p,
		input int sh);
		logic [PW-1:0] m;
		logic [PW-1:0] r;
		logic [PW:0]   s;
		m = p[PW-1] ? (~p + 1'b1) : p;
		r = m >> sh;
		s = p[PW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
		return sat(s);
	endfunction

	// fetch one column ahead so the entry is ready when its multiply runs
	assign rd_col = (cmd.diag_rd || cmd.update) ? row_idx
		: cmd.row_init ? '0
		: cmd.mac_acc ? IB'(col_idx + 1'b1) : col_idx;

	always_ff @(posedge clk) begin
		if (wr_a) mat_mem[{wr_row, wr_col}] <= wr_val;
		if (wr_b) rhs_mem[wr_row] <= wr_val;
		a_rd_q <= mat_mem[{row_idx, rd_col}];
		b_rd_q <= rhs_mem[row_idx];
	end

	sils_divider #(.VALUE_BITS(VB), .FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.numer(acc_q), .denom(a_rd_q), .done(div_done), .quot(div_q)
	);

	always_comb begin
		if (meth == METH_SOR) xnew = add_s(xi_q, shr_s(prod_q, OmegaBits));
		else xnew = g_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int k = 0; k < MAX_UNKNOWNS; k++) begin
				x_now_q[k]  <= '0;
				x_prev_q[k] <= (meth == METH_SOR) ? ONE : '0;
			end
		end
		// right-hand side arrives in the cycle after the row starts
		if (cmd.mac_mul && col_idx == '0) acc_q <= b_rd_q;
		if (cmd.mac_mul)
			prod_q <= PW'(a_rd_q) * PW'(x_prev_q[col_idx]);
		if (cmd.mac_acc && !col_skip) acc_q <= sub_s(acc_q, shr_s(prod_q, FRACTION_BITS));
		if (div_done) begin
			g_q  <= div_q;
			xi_q <= x_prev_q[row_idx];
		end
		if (cmd.sor_mul)
			prod_q <= PW'(sub_s(g_q, xi_q)) * $signed(PW'(omega));
		if (cmd.update) begin
			if (meth == METH_GS || meth == METH_SOR) begin
				x_now_q[row_idx]  <= xnew;
				x_prev_q[row_idx] <= xnew;
				if (abs_s(sub_s(xnew, xi_q)) > big_q) big_q <= abs_s(sub_s(xnew, xi_q));
			end else begin
				x_now_q[row_idx] <= g_q;
			end
		end
		if (cmd.jac_copy) begin
			if (abs_s(sub_s(x_now_q[row_idx], x_prev_q[row_idx])) > big_q)
				big_q <= abs_s(sub_s(x_now_q[row_idx], x_prev_q[row_idx]));
			x_prev_q[row_idx] <= x_now_q[row_idx];
		end
		if (cmd.sweep_clr || cmd.init) big_q <= '0;
	end

	assign stat.diag_zero = (a_rd_q == '0);
	assign stat.div_done  = div_done;
	assign stat.converged = big_q < $signed({1'b0, VB'(tol)});

	always_comb begin
		if (x_now_q[row_idx] > 64'sd2147483647) out_value = 32'h7fffffff;
		else if (x_now_q[row_idx] < -64'sd2147483648) out_value = 32'h80000000;
		else out_value = 32'(x_now_q[row_idx]);
	end
endmodule

>>> src/sils_controller.sv
`timescale 1ns / 1ps
module sils_controller
	import sils_pkg::*;
#(
	parameter int MAX_UNKNOWNS = MaxUnknowns
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  method_t                         meth,
	input  logic [15:0]                     max_it,
	input  logic [4:0]                      size,
	input  stat_t                           stat,
	output cmd_t                            cmd,
	output logic [$clog2(MAX_UNKNOWNS)-1:0] row_idx,
	output logic [$clog2(MAX_UNKNOWNS)-1:0] col_idx,
	output logic                            col_skip,
	output logic                            busy,
	output logic                            strobe,
	output logic                            last,
	output outcome_t                        outcome,
	output logic [15:0]                     iterations_used
);
	localparam int IB = $clog2(MAX_UNKNOWNS);
	localparam int LimN = (MAX_UNKNOWNS < 16) ? MAX_UNKNOWNS : 16;

	state_t          state_q, state_n;
	logic [IB-1:0]   row_q, col_q;
	logic [IB-1:0]   nm1_q;
	logic [15:0]     sweeps_q, limit_q;
	outcome_t        out_q;
	logic            inplace_q;
	logic            diag_wait_q;

	assign row_idx  = row_q;
	assign col_idx  = col_q;
	assign col_skip = (col_q == row_q);
	assign busy     = (state_q != ST_IDLE);
	assign iterations_used = sweeps_q;
	assign outcome  = out_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:      if (go) state_n = ST_DIAG;
			ST_DIAG:      if (diag_wait_q) begin
				if (stat.diag_zero) state_n = ST_EMIT;
				else if (row_q == nm1_q) state_n = ST_ROW_INIT;
			end
			ST_ROW_INIT:  state_n = ST_MAC_MUL;
			ST_MAC_MUL:   state_n = ST_MAC_ACC;
			ST_MAC_ACC:   state_n = (col_q == nm1_q) ? ST_DIV : ST_MAC_MUL;
			ST_DIV:       if (stat.div_done) state_n = ST_SOR_MUL;
			ST_SOR_MUL:   state_n = ST_UPDATE;
			ST_UPDATE:    if (row_q == nm1_q) state_n = inplace_q ? ST_SWEEP_END : ST_JAC_COPY;
				else state_n = ST_ROW_INIT;
			ST_JAC_COPY:  if (row_q == nm1_q) state_n = ST_SWEEP_END;
			ST_SWEEP_END: state_n = (stat.converged || sweeps_q >= limit_q) ? ST_EMIT
				: ST_ROW_INIT;
			ST_EMIT:      if (row_q == nm1_q) state_n = ST_IDLE;
			default:      state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		strobe = 1'b0;
		last = 1'b0;
		unique case (state_q)
			ST_IDLE:      cmd.init = go;
			ST_DIAG:      cmd.diag_rd = 1'b1;
			ST_ROW_INIT:  cmd.row_init = 1'b1;
			ST_MAC_MUL:   cmd.mac_mul = 1'b1;
			ST_MAC_ACC:   begin
				cmd.mac_acc = 1'b1;
				cmd.diag_rd = (col_q == nm1_q);
				cmd.div_start = 1'b0;
			end
			ST_DIV:       cmd.div_start = diag_wait_q;
			ST_SOR_MUL:   cmd.sor_mul = 1'b1;
			ST_UPDATE:    cmd.update = 1'b1;
			ST_JAC_COPY:  cmd.jac_copy = 1'b1;
			ST_SWEEP_END: cmd.sweep_clr = !(stat.converged || sweeps_q >= limit_q);
			ST_EMIT:      begin
				cmd.emit = 1'b1;
				strobe = 1'b1;
				last = (row_q == nm1_q);
			end
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			nm1_q       <= '0;
			sweeps_q    <= '0;
			limit_q     <= 16'd1;
			out_q       <= OUT_CONVERGED;
			inplace_q   <= 1'b0;
			diag_wait_q <= 1'b0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				ST_IDLE: if (go) begin
					row_q       <= '0;
					col_q       <= '0;
					sweeps_q    <= '0;
					diag_wait_q <= 1'b0;
					limit_q     <= (max_it == '0) ? 16'd1 : max_it;
					inplace_q   <= (meth == METH_GS) || (meth == METH_SOR);
					if (size == '0) nm1_q <= '0;
					else if (size > 5'(LimN)) nm1_q <= IB'(LimN - 1);
					else nm1_q <= IB'(size - 1'b1);
				end
				ST_DIAG: begin
					// diag_wait_q toggles: first the read is issued, then the registered entry is checked
					diag_wait_q <= !diag_wait_q;
					if (diag_wait_q) begin
						if (stat.diag_zero) begin
							out_q <= OUT_ZERO_DIAG;
							row_q <= '0;
						end else if (row_q == nm1_q) begin
							row_q    <= '0;
							sweeps_q <= 16'd1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				ST_ROW_INIT: col_q <= '0;
				ST_MAC_ACC: begin
					if (col_q != nm1_q) col_q <= col_q + 1'b1;
					diag_wait_q <= 1'b1;
				end
				ST_DIV: diag_wait_q <= 1'b0;
				ST_UPDATE: row_q <= (row_q == nm1_q) ? '0 : row_q + 1'b1;
				ST_JAC_COPY: row_q <= (row_q == nm1_q) ? '0 : row_q + 1'b1;
				ST_SWEEP_END: begin
					row_q <= '0;
					if (stat.converged) out_q <= OUT_CONVERGED;
					else if (sweeps_q >= limit_q) out_q <= OUT_LIMIT;
					else sweeps_q <= sweeps_q + 1'b1;
				end
				ST_EMIT: row_q <= row_q + 1'b1;
				default: row_q <= row_q;
			endcase
		end
	end

	property p_emit_bounded;
		@(posedge clk) disable iff (!arst_n) strobe |-> row_q <= nm1_q;
	endproperty
	a_emit_bounded: assert property (p_emit_bounded) else $error("emit row past size");

	property p_last_idle;
		@(posedge clk) disable iff (!arst_n) (strobe && last) |=> !busy;
	endproperty
	a_last_idle: assert property (p_last_idle) else $error("still busy after last");

	property p_sweeps_limit;
		@(posedge clk) disable iff (!arst_n) busy |-> sweeps_q <= limit_q;
	endproperty
	a_sweeps_limit: assert property (p_sweeps_limit) else $error("sweep count over limit");
endmodule

>>> src/stationary_iterative_linear_solver.sv
`timescale 1ns / 1ps
// Iterative solver for A x = B in signed Q16.16. Load transactions (action 0/1) are
// taken back to back and give no result. A start transaction (action 2) holds busy
// high while the solve runs: a diagonal check of each row, then sweeps in which the
// single multiply-accumulate unit walks each row and the bit-serial divider forms each
// new value, with a copy-back over the rows for Jacobi. The n solution transactions
// then follow on consecutive cycles, each on the result ports for one cycle under
// strobe; the receiver cannot stall them, so capture every strobed cycle. Start is
// ignored while busy is high.
module stationary_iterative_linear_solver
	import sils_pkg::*;
#(
	parameter int MAX_UNKNOWNS  = MaxUnknowns,
	parameter int VALUE_BITS    = ValueBits,
	parameter int FRACTION_BITS = FractionBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [3:0]         row_index,
	input  logic [3:0]         column_index,
	input  logic signed [31:0] entry_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	output logic               strobe,
	output logic [3:0]         element_index,
	output logic signed [31:0] solution_value,
	output logic               last,
	output logic [1:0]         outcome,
	output logic [15:0]        iterations_used
);
	localparam int IB = $clog2(MAX_UNKNOWNS);
	localparam logic signed [VALUE_BITS-1:0] QMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] QMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	method_t     method_q;
	logic [16:0] omega_q;
	logic [30:0] tol_q;
	logic [15:0] max_it_q;
	logic [4:0]  size_q;

	logic                    accept;
	logic                    in_range;
	logic signed [VALUE_BITS-1:0] val_sat;
	logic signed [63:0]      val_wide;
	cmd_t                    cmd;
	stat_t                   stat;
	logic [IB-1:0]           row_idx, col_idx;
	logic                    col_skip;
	outcome_t                out_code;
	logic signed [31:0]      out_val;

	// configuration registers: the user must write them only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METH_JACOBI;
			omega_q  <= 17'd81920;
			tol_q    <= 31'd1;
			max_it_q <= 16'd100;
			size_q   <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				3'(CfgMethod): method_q <= method_t'(cfg_data[1:0]);
				3'(CfgOmega):  omega_q  <= cfg_data[16:0];
				3'(CfgTol):    tol_q    <= cfg_data;
				3'(CfgMaxIt):  max_it_q <= cfg_data[15:0];
				3'(CfgSize):   size_q   <= cfg_data[4:0];
				default:       size_q   <= size_q;
			endcase
		end
	end

	assign accept = start && !busy;
	// drop loads that point beyond the store
	assign in_range = (32'(row_index) < MAX_UNKNOWNS) &&
		((action != ACT_LOAD_A) || (32'(column_index) < MAX_UNKNOWNS));

	// saturate the loaded value into the working width
	always_comb begin
		val_wide = 64'(entry_value);
		if (val_wide > 64'(QMAX)) val_sat = QMAX;
		else if (val_wide < 64'(QMIN)) val_sat = QMIN;
		else val_sat = VALUE_BITS'(val_wide);
	end

	sils_datapath #(
		.MAX_UNKNOWNS(MAX_UNKNOWNS), .VALUE_BITS(VALUE_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.wr_a(accept && action == ACT_LOAD_A && in_range),
		.wr_b(accept && action == ACT_LOAD_B && in_range),
		.wr_row(IB'(row_index)), .wr_col(IB'(column_index)), .wr_val(val_sat),
		.cmd(cmd), .row_idx(busy ? row_idx : IB'(row_index)), .col_idx(col_idx),
		.col_skip(col_skip), .meth(method_q), .omega(omega_q), .tol(tol_q),
		.stat(stat), .out_value(out_val)
	);

	sils_controller #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctl (
		.clk(clk), .arst_n(arst_n), .go(accept && action == ACT_START),
		.meth(method_q), .max_it(max_it_q), .size(size_q), .stat(stat),
		.cmd(cmd), .row_idx(row_idx), .col_idx(col_idx), .col_skip(col_skip),
		.busy(busy), .strobe(strobe), .last(last), .outcome(out_code),
		.iterations_used(iterations_used)
	);

	// zero-diagonal results carry zero values
	assign solution_value = (out_code == OUT_ZERO_DIAG) ? '0 : out_val;
	assign outcome        = out_code;
	assign element_index  = 4'(row_idx);
endmodule

>>> tb/sils_solution_checker.sv
`timescale 1ns / 1ps
module sils_solution_checker
	import sils_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         action,
	input  logic [3:0]         row_index,
	input  logic [3:0]         column_index,
	input  logic signed [31:0] entry_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               strobe,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] solution_value,
	input  logic               last,
	input  logic [1:0]         outcome,
	input  logic [15:0]        iterations_used,
	output int                 mismatches,
	output int                 outstanding
);
	localparam longint QMax = 64'sh7FFF_FFFF;
	localparam longint QMin = -QMax - 1;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] value;
		logic               final_elem;
		logic [1:0]         status;
		logic [15:0]        sweeps;
	} solution_elem_t;

	solution_elem_t pending_elems[$];

	method_t     meth;
	logic [16:0] omega;
	logic [30:0] tol;
	logic [15:0] sweep_limit;
	logic [4:0]  size_reg;

	longint amat[MaxUnknowns][MaxUnknowns];
	longint bvec[MaxUnknowns];
	longint xnew[MaxUnknowns];
	longint xold[MaxUnknowns];

	assign outstanding = pending_elems.size();

	function automatic longint sat_q(longint v);
		if (v > QMax) return QMax;
		if (v < QMin) return QMin;
		return v;
	endfunction

	function automatic longint sat_abs(longint v);
		if (v < 0) return (v < -QMax) ? QMax : -v;
		return v;
	endfunction

	function automatic longint signed_limit(bit neg, longint unsigned mag);
		if (!neg) return (mag > longint'(QMax)) ? QMax : longint'(mag);
		if (mag > longint'(QMax) + 1) return QMin;
		return -longint'(mag);
	endfunction

	// (a*b) >> sh, truncated toward zero
	function automatic longint fx_mul(longint a, longint b, int sh);
		longint unsigned ua, ub;
		ua = (a < 0) ? longint'(-a) : longint'(a);
		ub = (b < 0) ? longint'(-b) : longint'(b);
		return signed_limit((a < 0) != (b < 0), (ua * ub) >> sh);
	endfunction

	// (n << FractionBits) / d, truncated toward zero
	function automatic longint fx_div(longint n, longint d);
		longint unsigned un, ud;
		un = (n < 0) ? longint'(-n) : longint'(n);
		ud = (d < 0) ? longint'(-d) : longint'(d);
		return signed_limit((n < 0) != (d < 0), (un << FractionBits) / ud);
	endfunction

	function automatic longint row_estimate(int i, int n);
		longint s;
		s = bvec[i];
		for (int j = 0; j < n; j++)
			if (j != i) s = sat_q(s - fx_mul(amat[i][j], xold[j], FractionBits));
		return fx_div(s, amat[i][i]);
	endfunction

	task automatic solve_system();
		int n, limit, sweeps;
		logic [1:0] status;
		bit zero_diag, in_place;
		longint big, g, x, ch;
		solution_elem_t e;
		n = (size_reg == 0) ? 1 : ((size_reg > MaxUnknowns) ? MaxUnknowns : int'(size_reg));
		limit = (sweep_limit == 0) ? 1 : int'(sweep_limit);
		in_place = (meth == METH_GS) || (meth == METH_SOR);
		for (int i = 0; i < MaxUnknowns; i++) begin
			xnew[i] = 0;
			xold[i] = (meth == METH_SOR) ? (longint'(1) << FractionBits) : 0;
		end
		sweeps = 0;
		zero_diag = 0;
		for (int i = 0; i < n; i++)
			if (amat[i][i] == 0) zero_diag = 1;
		if (zero_diag) begin
			status = OUT_ZERO_DIAG;
		end else begin
			forever begin
				big = 0;
				sweeps++;
				for (int i = 0; i < n; i++) begin
					g = row_estimate(i, n);
					if (in_place) begin
						x = g;
						if (meth == METH_SOR)
							x = sat_q(xold[i] + fx_mul(sat_q(g - xold[i]),
								longint'(omega), OmegaBits));
						ch = sat_abs(sat_q(x - xold[i]));
						if (ch > big) big = ch;
						xnew[i] = x;
						xold[i] = x;
					end else begin
						xnew[i] = g;
					end
				end
				if (!in_place) begin
					for (int i = 0; i < n; i++) begin
						ch = sat_abs(sat_q(xnew[i] - xold[i]));
						if (ch > big) big = ch;
						xold[i] = xnew[i];
					end
				end
				if (big < longint'(tol)) begin
					status = OUT_CONVERGED;
					break;
				end
				if (sweeps >= limit) begin
					status = OUT_LIMIT;
					break;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			e.idx        = k[3:0];
			e.value      = xnew[k][31:0];
			e.final_elem = (k == n - 1);
			e.status     = status;
			e.sweeps     = sweeps[15:0];
			pending_elems.insert(pending_elems.size(), e);
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches  = 0;
			meth        = METH_JACOBI;
			omega       = 17'd81920;
			tol         = 31'd1;
			sweep_limit = 16'd100;
			size_reg    = 5'd16;
			pending_elems.delete();
		end else begin
			if (strobe) begin
				if (pending_elems.size() == 0) begin
					report_mismatch("unexpected element", element_index, -1);
				end else begin
					solution_elem_t w;
					w = pending_elems.pop_front();
					if (element_index !== w.idx)
						report_mismatch("element_index", element_index, w.idx);
					if (solution_value !== w.value)
						report_mismatch("solution_value", solution_value, w.value);
					if (last !== w.final_elem)
						report_mismatch("last", last, w.final_elem);
					if (outcome !== w.status)
						report_mismatch("outcome", outcome, w.status);
					if (iterations_used !== w.sweeps)
						report_mismatch("iterations_used", iterations_used, w.sweeps);
				end
			end
			if (cfg_we) begin
				case (int'(cfg_index))
					CfgMethod: meth        = method_t'(cfg_data[1:0]);
					CfgOmega:  omega       = cfg_data[16:0];
					CfgTol:    tol         = cfg_data;
					CfgMaxIt:  sweep_limit = cfg_data[15:0];
					CfgSize:   size_reg    = cfg_data[4:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (action_t'(action))
					ACT_LOAD_A: amat[row_index][column_index] = longint'(entry_value);
					ACT_LOAD_B: bvec[row_index] = longint'(entry_value);
					ACT_START:  solve_system();
					default: ;
				endcase
			end
		end
	end
endmodule

>>> tb/tb_stationary_iterative_linear_solver.sv
`timescale 1ns / 1ps
module tb_stationary_iterative_linear_solver;
	import sils_pkg::*;

	localparam int One         = 65536;   // 1.0 in Q16.16
	localparam int QuietLimit  = 250000;  // cycles with no transaction before giving up
	localparam int RandomItems = 205;
	localparam int CalmTail    = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         action = ACT_NONE;
	logic [3:0]         row_index = '0;
	logic [3:0]         column_index = '0;
	logic signed [31:0] entry_value = '0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;
	logic               strobe;
	logic [3:0]         element_index;
	logic signed [31:0] solution_value;
	logic               last;
	logic [1:0]         outcome;
	logic [15:0]        iterations_used;

	int mismatches;
	int outstanding;

	// which store entries hold a value; never start a solve that would read a hole
	bit a_loaded[MaxUnknowns][MaxUnknowns];
	bit b_loaded[MaxUnknowns];
	int items_sent = 0;
	bit calm = 1'b0;
	int cur_size = 16;
	int quiet = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stationary_iterative_linear_solver DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.row_index(row_index), .column_index(column_index), .entry_value(entry_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
		.element_index(element_index), .solution_value(solution_value), .last(last),
		.outcome(outcome), .iterations_used(iterations_used)
	);

	sils_solution_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.row_index(row_index), .column_index(column_index), .entry_value(entry_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
		.element_index(element_index), .solution_value(solution_value), .last(last),
		.outcome(outcome), .iterations_used(iterations_used),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// Watchdog: count cycles in which no transaction of any kind moves.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || cfg_we || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QuietLimit) begin
			$display("FAIL stationary_iterative_linear_solver");
			$finish;
		end
	end

	// Hold start low for a random burst now and then, outside the calm tail.
	task automatic idle_gap();
		int len;
		if (!calm && $urandom_range(0, 3) == 0) begin
			len = $urandom_range(1, 11);
			repeat (len) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
	endtask

	// Present one transaction and hold it until the block takes it.
	task automatic send(action_t a, int r, int c, logic [31:0] v);
		idle_gap();
		@(negedge clk);
		start        <= 1'b1;
		action       <= a;
		row_index    <= r[3:0];
		column_index <= c[3:0];
		entry_value  <= v;
		do @(posedge clk); while (busy);
		if (a == ACT_LOAD_A) a_loaded[r][c] = 1'b1;
		if (a == ACT_LOAD_B) b_loaded[r] = 1'b1;
		if (a != ACT_NONE) items_sent++;
	endtask

	// Drop start and wait until every expected element has come out and busy has fallen.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(int idx, logic [30:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data  <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Reprogram all registers, only ever with the block idle.
	task automatic setup(method_t m, int om, logic [30:0] tl, int mi, int sz);
		drain();
		write_reg(CfgMethod, 31'(m));
		write_reg(CfgOmega, 31'(om));
		write_reg(CfgTol, tl);
		write_reg(CfgMaxIt, 31'(mi));
		write_reg(CfgSize, 31'(sz));
		cur_size = (sz[4:0] == 0) ? 1 : ((sz[4:0] > MaxUnknowns) ? MaxUnknowns : int'(sz[4:0]));
	endtask

	function automatic int diag_value(int n);
		int mag;
		mag = (n + 1 + $urandom_range(0, 7)) * One + $urandom_range(0, One - 1);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Load a diagonally dominant system of size n; refresh a random share of
	// entries already loaded, and fill every hole. Optionally spoil one entry.
	task automatic load_system(int n, bit spoil);
		int v;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (!a_loaded[i][j] || $urandom_range(0, 2) != 0) begin
					v = (i == j) ? diag_value(n) : int'($urandom_range(0, 2 * One)) - One;
					send(ACT_LOAD_A, i, j, v);
				end
			end
			if (!b_loaded[i] || $urandom_range(0, 2) != 0)
				send(ACT_LOAD_B, i, 0, int'($urandom_range(0, 40 * One)) - 20 * One);
		end
		if (spoil) begin
			if ($urandom_range(0, 1))
				send(ACT_LOAD_A, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
			else begin
				v = $urandom_range(0, n - 1);
				send(ACT_LOAD_A, v, v, 0);
			end
		end
	endtask

	// Fill any hole a solve of the current size would read, then start it.
	task automatic start_solve();
		for (int i = 0; i < cur_size; i++) begin
			for (int j = 0; j < cur_size; j++)
				if (!a_loaded[i][j]) send(ACT_LOAD_A, i, j, (i == j) ? 4 * One : 0);
			if (!b_loaded[i]) send(ACT_LOAD_B, i, 0, One);
		end
		send(ACT_START, 0, 0, 0);
	endtask

	task automatic random_sequence();
		int pick, sz, mi, om;
		logic [30:0] tl;
		method_t m;
		m = method_t'($urandom_range(0, 3));
		om = $urandom_range(1, 131071);
		pick = $urandom_range(0, 5);
		case (pick)
			0: tl = '0;
			1: tl = 31'($urandom);
			2: tl = 31'($urandom_range(0, 255));
			default: tl = 31'($urandom_range(0, 8192));
		endcase
		pick = $urandom_range(0, 19);
		if (pick == 0) sz = 0;
		else if (pick == 1) sz = $urandom_range(16, 31);
		else sz = $urandom_range(1, 5);
		mi = $urandom_range(0, 12);
		if (sz >= 16) mi = $urandom_range(1, 3);
		setup(m, om, tl, mi, sz);
		load_system(cur_size, $urandom_range(0, 5) == 0);
		start_solve();
	endtask

	// Noise: loads anywhere with any value, ignored actions, the odd bare start.
	task automatic noise_burst();
		int len, pick;
		len = $urandom_range(1, 6);
		repeat (len) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				send(ACT_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
			else if (pick < 7)
				send(ACT_LOAD_B, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
			else if (pick < 9)
				send(ACT_NONE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
			else
				start_solve();
		end
	endtask

	initial begin
		int target;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed: a small dominant 2x2 system under each method.
		setup(METH_JACOBI, 81920, 31'd16, 40, 2);
		send(ACT_LOAD_A, 0, 0, 4 * One);
		send(ACT_LOAD_A, 0, 1, One);
		send(ACT_LOAD_A, 1, 0, -One);
		send(ACT_LOAD_A, 1, 1, 3 * One);
		send(ACT_LOAD_B, 0, 0, 5 * One);
		send(ACT_LOAD_B, 1, 0, 2 * One);
		send(ACT_START, 0, 0, 0);
		setup(METH_GS, 81920, 31'd16, 40, 2);
		send(ACT_START, 0, 0, 0);
		setup(METH_SOR, 81920, 31'd16, 40, 2);
		send(ACT_START, 0, 0, 0);
		// unknown method falls back to Jacobi
		setup(METH_OTHER, 81920, 31'd16, 40, 2);
		send(ACT_START, 0, 0, 0);
		// smallest and largest omega
		setup(METH_SOR, 1, 31'd16, 3, 2);
		send(ACT_START, 0, 0, 0);
		setup(METH_SOR, 131071, 31'd16, 3, 2);
		send(ACT_START, 0, 0, 0);
		// zero tolerance never converges; a zero sweep limit means one sweep
		setup(METH_JACOBI, 81920, 31'd0, 0, 2);
		send(ACT_START, 0, 0, 0);
		// zero on the diagonal stops before any sweep
		send(ACT_LOAD_A, 1, 1, 0);
		send(ACT_START, 0, 0, 0);
		send(ACT_LOAD_A, 1, 1, 3 * One);
		// extremes of the value range drive every stage into saturation
		setup(METH_GS, 81920, 31'd1, 2, 2);
		send(ACT_LOAD_B, 0, 0, 32'h7FFF_FFFF);
		send(ACT_LOAD_A, 0, 1, 32'h8000_0000);
		send(ACT_START, 0, 0, 0);
		send(ACT_LOAD_B, 1, 0, 32'h8000_0000);
		send(ACT_START, 0, 0, 0);
		// size zero behaves as one unknown
		setup(METH_JACOBI, 81920, 31'd16, 5, 0);
		send(ACT_START, 0, 0, 0);
		send(ACT_NONE, 15, 15, 32'hFFFF_FFFF);
		send(ACT_NONE, 0, 0, 0);

		// Pause the sender until every expected element has arrived.
		drain();
		target = items_sent + RandomItems;

		// Largest sweep limit, omega and tolerance; converges at once.
		setup(METH_GS, 131071, 31'h7FFF_FFFF, 65535, 4);
		load_system(4, 1'b0);
		start_solve();
		// Largest sweep limit on a small system that settles well inside it.
		setup(METH_JACOBI, 81920, 31'd64, 65535, 2);
		load_system(2, 1'b0);
		start_solve();
		// Bring the sweep limit down before noise can spoil the loaded system.
		setup(METH_JACOBI, 81920, 31'd64, 8, 2);

		while (items_sent < target) begin
			if (items_sent >= target - CalmTail) calm = 1'b1;
			if ($urandom_range(0, 9) < 7) random_sequence();
			else noise_burst();
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("PASS stationary_iterative_linear_solver");
		else
			$display("FAIL stationary_iterative_linear_solver");
		$finish;
	end
endmodule
